// ===== rtl/core/dihedral_rest_angle_defines.svh =====
// ----------------------------------------------------------------------------
// Dihedral rest angle: assertion macros
// Shared property forms for the checker of the dihedral angle pipeline.
// ----------------------------------------------------------------------------
`ifndef DIHEDRAL_REST_ANGLE_DEFINES_SVH
`define DIHEDRAL_REST_ANGLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRA_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dihedral_rest_angle: check failed");

// Consequent must hold a fixed number of cycles after the antecedent.
`define DRA_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("dihedral_rest_angle: latency check failed");

`endif

// ===== rtl/core/dra_pkg.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle: package
// Word types, fixed widths and CORDIC constants shared by the pipeline.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int ANGLE_W       = 18;
  localparam int CORDIC_ITERS  = 28;
  localparam int ZW            = 33;

  localparam logic signed [ZW-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic [ANGLE_W-1:0]   ANGLE_PI_Q16 = 18'd205887;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic signed [COORD_W-1:0] d_x;
    logic signed [COORD_W-1:0] d_y;
    logic signed [COORD_W-1:0] d_z;
  } dra_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               degenerate;
  } dra_out_t;

  // Arctangent of 2^-i in Q.30, truncated.
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 33'sh03243F6A8;
      1:  r = 33'sh01DAC6705;
      2:  r = 33'sh00FADBAFC;
      3:  r = 33'sh007F56EA6;
      4:  r = 33'sh003FEAB76;
      5:  r = 33'sh001FFD55B;
      6:  r = 33'sh000FFFAAA;
      7:  r = 33'sh0007FFF55;
      8:  r = 33'sh0003FFFEA;
      9:  r = 33'sh0001FFFFD;
      10: r = 33'sh0000FFFFF;
      11: r = 33'sh00007FFFF;
      12: r = 33'sh00003FFFF;
      13: r = 33'sh00001FFFF;
      14: r = 33'sh00000FFFF;
      15: r = 33'sh000007FFF;
      16: r = 33'sh000003FFF;
      17: r = 33'sh000001FFF;
      18: r = 33'sh000000FFF;
      19: r = 33'sh0000007FF;
      20: r = 33'sh0000003FF;
      21: r = 33'sh0000001FF;
      22: r = 33'sh0000000FF;
      23: r = 33'sh00000007F;
      24: r = 33'sh00000003F;
      25: r = 33'sh00000001F;
      26: r = 33'sh00000000F;
      27: r = 33'sh000000008;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dra_isqrt.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle: pipelined integer square root
// Floor square root, one result bit per stage, with a word tag carried along.
// ----------------------------------------------------------------------------
module dra_isqrt #(
  parameter int IN_W  = 62,
  parameter int TAG_W = 1,
  localparam int OUT_W = (IN_W + 1) / 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [IN_W-1:0]  in_val,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [OUT_W-1:0] out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int RW = 2 * OUT_W + 1;

  logic [RW-1:0]    rem  [OUT_W];
  logic [OUT_W-1:0] root [OUT_W];
  logic [TAG_W-1:0] tag  [OUT_W];
  logic             vld  [OUT_W];

  for (genvar j = 0; j < OUT_W; j++) begin : g_step
    localparam int K = OUT_W - 1 - j;
    logic [RW-1:0]    rem_cur;
    logic [OUT_W-1:0] root_cur;
    logic [TAG_W-1:0] tag_cur;
    logic             vld_cur;
    logic [RW-1:0]    delta;
    logic             fit;

    if (j == 0) begin : g_first
      assign rem_cur  = RW'(in_val);
      assign root_cur = '0;
      assign tag_cur  = in_tag;
      assign vld_cur  = in_vld;
    end else begin : g_next
      assign rem_cur  = rem[j-1];
      assign root_cur = root[j-1];
      assign tag_cur  = tag[j-1];
      assign vld_cur  = vld[j-1];
    end

    // (root + 2^K)^2 - root^2, the bits of root being all above K.
    assign delta = (RW'(root_cur) << (K + 1)) | (RW'(1) << (2 * K));
    assign fit   = rem_cur >= delta;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      rem[j]  <= fit ? rem_cur - delta : rem_cur;
      root[j] <= fit ? root_cur | (OUT_W'(1) << K) : root_cur;
      tag[j]  <= tag_cur;
    end
  end

  assign out_vld  = vld[OUT_W-1];
  assign out_root = root[OUT_W-1];
  assign out_tag  = tag[OUT_W-1];

endmodule

// ===== rtl/core/dra_acos.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle: arc cosine
// Sine by square root, then CORDIC vectoring to the Q.16 angle, pipelined.
// ----------------------------------------------------------------------------
module dra_acos import dra_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic signed [FRAC_BITS+1:0] in_cos,
  input  logic                      in_deg,
  output logic                      out_vld,
  output dra_out_t                  out_word
);

  localparam int AW  = FRAC_BITS + 1;
  localparam int SQW = 2 * FRAC_BITS + 2;
  localparam int DFW = 2 * FRAC_BITS + 1;
  localparam int CW  = 34;
  localparam int TW  = AW + 2;

  // Stage 1: magnitude of the cosine.
  logic          a1_vld, a1_neg, a1_deg;
  logic [AW-1:0] a1_ax;
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_vld <= 1'b0;
    end else begin
      a1_vld <= in_vld;
    end
  end
  always_ff @(posedge clk) begin
    a1_neg <= in_cos[FRAC_BITS+1];
    a1_deg <= in_deg;
    a1_ax  <= in_cos[FRAC_BITS+1] ? AW'(-in_cos) : AW'(in_cos);
  end

  // Stage 2: square.
  logic           a2_vld, a2_neg, a2_deg;
  logic [AW-1:0]  a2_ax;
  logic [SQW-1:0] a2_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      a2_vld <= 1'b0;
    end else begin
      a2_vld <= a1_vld;
    end
  end
  always_ff @(posedge clk) begin
    a2_neg <= a1_neg;
    a2_deg <= a1_deg;
    a2_ax  <= a1_ax;
    a2_sq  <= SQW'(a1_ax) * SQW'(a1_ax);
  end

  // Stage 3: one minus the square; never negative since |cos| <= 1.
  logic           a3_vld;
  logic [TW-1:0]  a3_tag;
  logic [DFW-1:0] a3_diff;
  always_ff @(posedge clk) begin
    if (rst) begin
      a3_vld <= 1'b0;
    end else begin
      a3_vld <= a2_vld;
    end
  end
  always_ff @(posedge clk) begin
    a3_tag  <= {a2_deg, a2_neg, a2_ax};
    a3_diff <= DFW'((SQW'(1) << (2 * FRAC_BITS)) - a2_sq);
  end

  logic          sq_vld;
  logic [AW-1:0] sq_root;
  logic [TW-1:0] sq_tag;

  dra_isqrt #(
    .IN_W  (DFW),
    .TAG_W (TW)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (a3_vld),
    .in_val   (a3_diff),
    .in_tag   (a3_tag),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  // Stage 4: load the vector in Q.30.
  logic                 c0_vld, c0_neg, c0_deg;
  logic signed [CW-1:0] c0_x, c0_y;
  always_ff @(posedge clk) begin
    if (rst) begin
      c0_vld <= 1'b0;
    end else begin
      c0_vld <= sq_vld;
    end
  end
  always_ff @(posedge clk) begin
    c0_deg <= sq_tag[TW-1];
    c0_neg <= sq_tag[TW-2];
    c0_x   <= $signed(CW'(sq_tag[AW-1:0]) << (30 - FRAC_BITS));
    c0_y   <= $signed(CW'(sq_root) << (30 - FRAC_BITS));
  end

  logic signed [CW-1:0] cx  [CORDIC_ITERS];
  logic signed [CW-1:0] cy  [CORDIC_ITERS];
  logic signed [ZW-1:0] cz  [CORDIC_ITERS];
  logic                 cv  [CORDIC_ITERS];
  logic                 cn  [CORDIC_ITERS];
  logic                 cd  [CORDIC_ITERS];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = atan_q30(i);
    logic signed [CW-1:0] x_cur, y_cur;
    logic signed [ZW-1:0] z_cur;
    logic                 v_cur, n_cur, d_cur;

    if (i == 0) begin : g_first
      assign x_cur = c0_x;
      assign y_cur = c0_y;
      assign z_cur = '0;
      assign v_cur = c0_vld;
      assign n_cur = c0_neg;
      assign d_cur = c0_deg;
    end else begin : g_next
      assign x_cur = cx[i-1];
      assign y_cur = cy[i-1];
      assign z_cur = cz[i-1];
      assign v_cur = cv[i-1];
      assign n_cur = cn[i-1];
      assign d_cur = cd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i] <= 1'b0;
      end else begin
        cv[i] <= v_cur;
      end
    end

    // Rotate toward the x axis; zero y counts as the negative direction.
    always_ff @(posedge clk) begin
      cn[i] <= n_cur;
      cd[i] <= d_cur;
      if (y_cur > 0) begin
        cx[i] <= x_cur + (y_cur >>> i);
        cy[i] <= y_cur - (x_cur >>> i);
        cz[i] <= z_cur + ATAN;
      end else begin
        cx[i] <= x_cur - (y_cur >>> i);
        cy[i] <= y_cur + (x_cur >>> i);
        cz[i] <= z_cur - ATAN;
      end
    end
  end

  // Final stage: clamp to the first quadrant, fold for negative cosine, round; degenerate words give zero.
  logic signed [ZW-1:0] z_clamp, z_fold;
  logic [ZW-1:0]        z_rnd;
  always_comb begin
    if (cz[CORDIC_ITERS-1] < 0) begin
      z_clamp = '0;
    end else if (cz[CORDIC_ITERS-1] > HALF_PI_Q30) begin
      z_clamp = HALF_PI_Q30;
    end else begin
      z_clamp = cz[CORDIC_ITERS-1];
    end
    z_fold = cn[CORDIC_ITERS-1] ? PI_Q30 - z_clamp : z_clamp;
    z_rnd  = ZW'(z_fold) + ZW'(8192);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= cv[CORDIC_ITERS-1];
    end
  end
  always_ff @(posedge clk) begin
    out_word.degenerate <= cd[CORDIC_ITERS-1];
    out_word.angle      <= cd[CORDIC_ITERS-1] ? '0 : z_rnd[14 +: ANGLE_W];
  end

endmodule

// ===== rtl/core/dihedral_rest_angle.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle
// Angle between the normals of two triangles that share the edge A-B.
// ----------------------------------------------------------------------------
//   channel   signals                 direction   transfer
//   item      start, busy, item       in          start high, busy low
//   result    done, result            out         done high for one cycle
//
// Fully pipelined: one word enters every clock and busy stays low.
// Each word passes the normal stages, the two length square roots side by side,
// the divide, the dot product and the arc cosine with its 28 CORDIC stages.
// Synchronous reset clears every stage valid bit; words in flight are dropped.
// The result side has no back pressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module dihedral_rest_angle import dra_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dra_in_t  item,
  output logic     done,
  output dra_out_t result
);

  localparam int DW  = COORD_W + 1;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1;
  localparam int VW  = 30;
  localparam int SW  = 2 * VW + 2;
  localparam int LW  = SW / 2;
  localparam int TGW = 3 * VW + 4;
  localparam int QNW = VW + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int QSW = FRAC_BITS + 2;
  localparam int DPW = 2 * QSW;
  localparam int DSW = DPW + 2;
  localparam int LATENCY = 8 + LW + 1 + QW + 5 + (FRAC_BITS + 34);

  logic take;
  assign busy = 1'b0;
  assign take = start & ~busy;

  function automatic logic [6:0] bit_len(input logic [NW-1:0] v);
    logic [6:0] r;
    r = '0;
    for (int b = 0; b < NW; b++) begin
      if (v[b]) r = 7'(b + 1);
    end
    return r;
  endfunction

  // Stage 1: edge and wing vectors.
  logic                 s1_vld;
  logic signed [DW-1:0] e [3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] w [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= take;
    end
  end
  always_ff @(posedge clk) begin
    e[0] <= DW'(item.b_x) - DW'(item.a_x);
    e[1] <= DW'(item.b_y) - DW'(item.a_y);
    e[2] <= DW'(item.b_z) - DW'(item.a_z);
    u[0] <= DW'(item.c_x) - DW'(item.a_x);
    u[1] <= DW'(item.c_y) - DW'(item.a_y);
    u[2] <= DW'(item.c_z) - DW'(item.a_z);
    w[0] <= DW'(item.d_x) - DW'(item.a_x);
    w[1] <= DW'(item.d_y) - DW'(item.a_y);
    w[2] <= DW'(item.d_z) - DW'(item.a_z);
  end

  // Stage 2: cross product terms.
  logic                 s2_vld;
  logic signed [PW-1:0] p [12];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end
  always_ff @(posedge clk) begin
    p[0]  <= e[1] * u[2];
    p[1]  <= e[2] * u[1];
    p[2]  <= e[2] * u[0];
    p[3]  <= e[0] * u[2];
    p[4]  <= e[0] * u[1];
    p[5]  <= e[1] * u[0];
    p[6]  <= e[1] * w[2];
    p[7]  <= e[2] * w[1];
    p[8]  <= e[2] * w[0];
    p[9]  <= e[0] * w[2];
    p[10] <= e[0] * w[1];
    p[11] <= e[1] * w[0];
  end

  // Stage 3: exact normals; components 0..2 are n1, 3..5 are n2.
  logic                 s3_vld;
  logic signed [NW-1:0] n [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      n[i] <= NW'(p[2*i]) - NW'(p[2*i+1]);
    end
  end

  // Stage 4: sign and magnitude.
  logic                 s4_vld;
  logic [5:0][NW-1:0]   s4_mag;
  logic [5:0]           s4_neg;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      s4_neg[i] <= n[i][NW-1];
      s4_mag[i] <= n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
    end
  end

  // Stage 5: bit length of the largest component of each normal.
  logic               s5_vld;
  logic [5:0][NW-1:0] s5_mag;
  logic [5:0]         s5_neg;
  logic [6:0]         s5_top [2];
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end
  always_ff @(posedge clk) begin
    s5_mag    <= s4_mag;
    s5_neg    <= s4_neg;
    s5_top[0] <= bit_len(s4_mag[0] | s4_mag[1] | s4_mag[2]);
    s5_top[1] <= bit_len(s4_mag[3] | s4_mag[4] | s4_mag[5]);
  end

  // Stage 6: block scaling so the largest magnitude has its top bit at 29.
  logic               s6_vld;
  logic [5:0][VW-1:0] s6_v;
  logic [5:0]         s6_neg;
  logic [1:0]         s6_zero;
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else begin
      s6_vld <= s5_vld;
    end
  end
  always_ff @(posedge clk) begin
    s6_neg     <= s5_neg;
    s6_zero[0] <= s5_top[0] == '0;
    s6_zero[1] <= s5_top[1] == '0;
    for (int i = 0; i < 6; i++) begin
      if (s5_top[i/3] > 7'(VW)) begin
        s6_v[i] <= VW'(s5_mag[i] >> (s5_top[i/3] - 7'(VW)));
      end else begin
        s6_v[i] <= VW'(s5_mag[i] << (7'(VW) - s5_top[i/3]));
      end
    end
  end

  // Stage 7: squares.
  logic                 s7_vld;
  logic [5:0][VW-1:0]   s7_v;
  logic [5:0]           s7_neg;
  logic [1:0]           s7_zero;
  logic [5:0][2*VW-1:0] s7_sq;
  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else begin
      s7_vld <= s6_vld;
    end
  end
  always_ff @(posedge clk) begin
    s7_v    <= s6_v;
    s7_neg  <= s6_neg;
    s7_zero <= s6_zero;
    for (int i = 0; i < 6; i++) begin
      s7_sq[i] <= (2*VW)'(s6_v[i]) * (2*VW)'(s6_v[i]);
    end
  end

  // Stage 8: squared lengths, packed with the scaled normal for the root.
  logic           s8_vld;
  logic [SW-1:0]  s8_sum [2];
  logic [TGW-1:0] s8_tag [2];
  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else begin
      s8_vld <= s7_vld;
    end
  end
  always_ff @(posedge clk) begin
    s8_sum[0] <= SW'(s7_sq[0]) + SW'(s7_sq[1]) + SW'(s7_sq[2]);
    s8_sum[1] <= SW'(s7_sq[3]) + SW'(s7_sq[4]) + SW'(s7_sq[5]);
    s8_tag[0] <= {s7_zero[0], s7_neg[2:0], s7_v[2:0]};
    s8_tag[1] <= {s7_zero[1], s7_neg[5:3], s7_v[5:3]};
  end

  logic           rt_vld [2];
  logic [LW-1:0]  rt_len [2];
  logic [TGW-1:0] rt_tag [2];

  for (genvar k = 0; k < 2; k++) begin : g_len
    dra_isqrt #(
      .IN_W  (SW),
      .TAG_W (TGW)
    ) u_isqrt (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (s8_vld),
      .in_val   (s8_sum[k]),
      .in_tag   (s8_tag[k]),
      .out_vld  (rt_vld[k]),
      .out_root (rt_len[k]),
      .out_tag  (rt_tag[k])
    );
  end

  // Divide setup: numerator is the scaled component plus half the length.
  logic                nm_vld, nm_deg;
  logic [5:0][QNW-1:0] nm_rem;
  logic [5:0]          nm_neg;
  logic [1:0][LW-1:0]  nm_len;
  always_ff @(posedge clk) begin
    if (rst) begin
      nm_vld <= 1'b0;
    end else begin
      nm_vld <= rt_vld[0] & rt_vld[1];
    end
  end
  always_ff @(posedge clk) begin
    nm_deg      <= rt_tag[0][TGW-1] | rt_tag[1][TGW-1];
    nm_neg[2:0] <= rt_tag[0][TGW-2 -: 3];
    nm_neg[5:3] <= rt_tag[1][TGW-2 -: 3];
    nm_len[0]   <= rt_len[0];
    nm_len[1]   <= rt_len[1];
    for (int i = 0; i < 6; i++) begin
      nm_rem[i] <= (QNW'(rt_tag[i/3][(i%3)*VW +: VW]) << FRAC_BITS) +
                   QNW'(rt_len[i/3] >> 1);
    end
  end

  // Restoring division, one quotient bit per stage for all six components.
  logic [5:0][QNW-1:0] dv_rem [QW];
  logic [5:0][QW-1:0]  dv_quo [QW];
  logic [5:0]          dv_neg [QW];
  logic [1:0][LW-1:0]  dv_len [QW];
  logic                dv_deg [QW];
  logic                dv_vld [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [5:0][QNW-1:0] rem_cur;
    logic [5:0][QW-1:0]  quo_cur;
    logic [5:0]          neg_cur;
    logic [1:0][LW-1:0]  len_cur;
    logic                deg_cur, vld_cur;

    if (j == 0) begin : g_first
      assign rem_cur = nm_rem;
      assign quo_cur = '0;
      assign neg_cur = nm_neg;
      assign len_cur = nm_len;
      assign deg_cur = nm_deg;
      assign vld_cur = nm_vld;
    end else begin : g_next
      assign rem_cur = dv_rem[j-1];
      assign quo_cur = dv_quo[j-1];
      assign neg_cur = dv_neg[j-1];
      assign len_cur = dv_len[j-1];
      assign deg_cur = dv_deg[j-1];
      assign vld_cur = dv_vld[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else begin
        dv_vld[j] <= vld_cur;
      end
    end

    for (genvar c = 0; c < 6; c++) begin : g_comp
      logic [QNW:0] sub;
      logic         fit;
      assign sub = (QNW + 1)'(len_cur[c/3]) << K;
      assign fit = (QNW + 1)'(rem_cur[c]) >= sub;
      always_ff @(posedge clk) begin
        dv_rem[j][c] <= fit ? QNW'((QNW + 1)'(rem_cur[c]) - sub) : rem_cur[c];
        dv_quo[j][c] <= fit ? quo_cur[c] | (QW'(1) << K) : quo_cur[c];
      end
    end

    always_ff @(posedge clk) begin
      dv_neg[j] <= neg_cur;
      dv_len[j] <= len_cur;
      dv_deg[j] <= deg_cur;
    end
  end

  // Signed unit-vector components in Q.FRAC_BITS.
  logic                  uq_vld, uq_deg;
  logic signed [QSW-1:0] uq [6];
  always_ff @(posedge clk) begin
    if (rst) begin
      uq_vld <= 1'b0;
    end else begin
      uq_vld <= dv_vld[QW-1];
    end
  end
  always_ff @(posedge clk) begin
    uq_deg <= dv_deg[QW-1];
    for (int i = 0; i < 6; i++) begin
      uq[i] <= dv_neg[QW-1][i] ? -$signed({1'b0, dv_quo[QW-1][i]})
                               : $signed({1'b0, dv_quo[QW-1][i]});
    end
  end

  // Dot product terms.
  logic                  dp_vld, dp_deg;
  logic signed [DPW-1:0] dp [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      dp_vld <= 1'b0;
    end else begin
      dp_vld <= uq_vld;
    end
  end
  always_ff @(posedge clk) begin
    dp_deg <= uq_deg;
    for (int i = 0; i < 3; i++) begin
      dp[i] <= DPW'(uq[i]) * DPW'(uq[i+3]);
    end
  end

  // Dot product sum.
  logic                  ds_vld, ds_deg;
  logic signed [DSW-1:0] ds;
  always_ff @(posedge clk) begin
    if (rst) begin
      ds_vld <= 1'b0;
    end else begin
      ds_vld <= dp_vld;
    end
  end
  always_ff @(posedge clk) begin
    ds_deg <= dp_deg;
    ds     <= DSW'(dp[0]) + DSW'(dp[1]) + DSW'(dp[2]);
  end

  // Magnitude of the dot product.
  logic           da_vld, da_deg, da_neg;
  logic [DSW-1:0] da_mag;
  always_ff @(posedge clk) begin
    if (rst) begin
      da_vld <= 1'b0;
    end else begin
      da_vld <= ds_vld;
    end
  end
  always_ff @(posedge clk) begin
    da_deg <= ds_deg;
    da_neg <= ds[DSW-1];
    da_mag <= ds[DSW-1] ? DSW'(-ds) : DSW'(ds);
  end

  // Round half away from zero to Q.FRAC_BITS and clamp to one.
  logic [DSW:0]  rnd;
  logic [DSW:0]  rsh;
  logic [QW-1:0] cmag;
  always_comb begin
    rnd  = (DSW + 1)'(da_mag) + ((DSW + 1)'(1) << (FRAC_BITS - 1));
    rsh  = rnd >> FRAC_BITS;
    cmag = (rsh > ((DSW + 1)'(1) << FRAC_BITS)) ? (QW'(1) << FRAC_BITS) : QW'(rsh);
  end

  logic                  cs_vld, cs_deg;
  logic signed [QSW-1:0] cs;
  always_ff @(posedge clk) begin
    if (rst) begin
      cs_vld <= 1'b0;
    end else begin
      cs_vld <= da_vld;
    end
  end
  always_ff @(posedge clk) begin
    cs_deg <= da_deg;
    cs     <= da_neg ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
  end

  dra_acos #(
    .FRAC_BITS (FRAC_BITS)
  ) u_acos (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (cs_vld),
    .in_cos   (cs),
    .in_deg   (cs_deg),
    .out_vld  (done),
    .out_word (result)
  );

endmodule

// ===== rtl/core/dra_checker.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle: port checker
// Latency and result checks seen at the ports of the top level.
// ----------------------------------------------------------------------------
`include "dihedral_rest_angle_defines.svh"

module dra_checker import dra_pkg::*; #(
  parameter int LAT = 112
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input dra_out_t result
);

  // Every accepted word leaves after exactly the pipeline depth.
  `DRA_ASSERT_DELAY(a_latency, start && !busy, LAT, done)
  // No result without a matching accepted word.
  `DRA_ASSERT_IMPLIES(a_no_spurious, done, $past(start && !busy, LAT))
  `DRA_ASSERT_IMPLIES(a_degen_zero, done && result.degenerate, result.angle == '0)
  `DRA_ASSERT_IMPLIES(a_angle_range, done, result.angle <= ANGLE_PI_Q16)

endmodule

bind dihedral_rest_angle dra_checker #(.LAT(LATENCY)) u_dra_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Dihedral rest angle testbench
// Drives point quadruples into the pipeline and predicts each angle and
// degenerate flag with its own wide-integer model. A scoreboard compares every
// result word with the oldest prediction. Sender gaps vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import dra_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES = 2 * FB + 100;

  localparam longint ATAN_Q30 [28] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008
  };

  typedef logic signed [127:0] wide_t;

  class angle_scoreboard;
    dra_out_t pending[$];
    int errors;
    int words_in;
    int words_out;
    int degenerate_seen;

    function automatic longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Block-scales a normal so its largest component sits in [2^29, 2^30),
    // then divides by the length to get a unit vector in Q.FB.
    function automatic bit unit_vec(input wide_t n [3], output longint q [3]);
      logic [127:0] m [3];
      bit ng [3];
      int top;
      longint unsigned v [3];
      longint unsigned s;
      longint unsigned len;
      longint unsigned k;
      top = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        ng[i] = n[i][127];
        m[i] = ng[i] ? -n[i] : n[i];
        for (int b = 0; b < 128; b++) if (m[i][b] && b + 1 > top) top = b + 1;
      end
      if (top == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        if (top > 30) v[i] = 64'(m[i] >> (top - 30));
        else v[i] = 64'(m[i] << (30 - top));
        v[i] = v[i] & 64'h3FFF_FFFF;
        s = s + v[i] * v[i];
      end
      len = root(s);
      for (int i = 0; i < 3; i++) begin
        k = ((v[i] << FB) + (len >> 1)) / len;
        q[i] = ng[i] ? -longint'(k) : longint'(k);
      end
      return 1;
    endfunction

    function automatic logic [ANGLE_W-1:0] arc_cos(longint c);
      longint ax;
      longint cx;
      longint cy;
      longint z;
      longint dx;
      longint dy;
      ax = c < 0 ? -c : c;
      cx = ax << (30 - FB);
      cy = longint'(root(longint'(1) << (2 * FB)) * 0 +
                    root((longint'(1) << (2 * FB)) - ax * ax)) << (30 - FB);
      z = 0;
      for (int i = 0; i < 28; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + ATAN_Q30[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - ATAN_Q30[i];
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(HALF_PI_Q30)) z = longint'(HALF_PI_Q30);
      if (c < 0) z = longint'(PI_Q30) - z;
      return ANGLE_W'((z + (longint'(1) << 13)) >> 14);
    endfunction

    function automatic dra_out_t dihedral(dra_in_t x);
      longint p [12];
      longint e [3];
      longint u [3];
      longint w [3];
      wide_t n1 [3];
      wide_t n2 [3];
      longint q1 [3];
      longint q2 [3];
      longint dot;
      longint dm;
      longint cosv;
      dra_out_t r;
      p = '{x.a_x, x.a_y, x.a_z, x.b_x, x.b_y, x.b_z,
            x.c_x, x.c_y, x.c_z, x.d_x, x.d_y, x.d_z};
      for (int i = 0; i < 3; i++) begin
        e[i] = p[3 + i] - p[i];
        u[i] = p[6 + i] - p[i];
        w[i] = p[9 + i] - p[i];
      end
      n1[0] = wide_t'(e[1]) * wide_t'(u[2]) - wide_t'(e[2]) * wide_t'(u[1]);
      n1[1] = wide_t'(e[2]) * wide_t'(u[0]) - wide_t'(e[0]) * wide_t'(u[2]);
      n1[2] = wide_t'(e[0]) * wide_t'(u[1]) - wide_t'(e[1]) * wide_t'(u[0]);
      n2[0] = wide_t'(e[1]) * wide_t'(w[2]) - wide_t'(e[2]) * wide_t'(w[1]);
      n2[1] = wide_t'(e[2]) * wide_t'(w[0]) - wide_t'(e[0]) * wide_t'(w[2]);
      n2[2] = wide_t'(e[0]) * wide_t'(w[1]) - wide_t'(e[1]) * wide_t'(w[0]);
      r = '0;
      if (!unit_vec(n1, q1) || !unit_vec(n2, q2)) begin
        r.degenerate = 1'b1;
        return r;
      end
      dot = q1[0] * q2[0] + q1[1] * q2[1] + q1[2] * q2[2];
      dm = ((dot < 0 ? -dot : dot) + (longint'(1) << (FB - 1))) >> FB;
      cosv = dot < 0 ? -dm : dm;
      if (cosv > (longint'(1) << FB)) cosv = longint'(1) << FB;
      if (cosv < -(longint'(1) << FB)) cosv = -(longint'(1) << FB);
      r.angle = arc_cos(cosv);
      return r;
    endfunction

    function void note_input(dra_in_t x);
      pending.insert(pending.size(), dihedral(x));
      words_in++;
    endfunction

    function void check_result(dra_out_t got);
      dra_out_t want;
      words_out++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result angle=%0d degenerate=%0b",
                 $time, got.angle, got.degenerate);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.degenerate) degenerate_seen++;
      if (got.angle !== want.angle) begin
        $display("%0t: angle mismatch expected %0d actual %0d",
                 $time, want.angle, got.angle);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate mismatch expected %0b actual %0b",
                 $time, want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  dra_in_t item;
  logic done;
  dra_out_t result;

  angle_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  dihedral_rest_angle dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  // Scoreboard hooks and the watchdog, all sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_input(item);
    if (!rst && done) sb.check_result(result);
    if (!rst && ((start && !busy) || done)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic send_word(dra_in_t x);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [31:0] coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic dra_in_t random_quad();
    dra_in_t x;
    int mode;
    int shape;
    mode = $urandom_range(0, 3);
    shape = $urandom_range(0, 19);
    x.a_x = coord(mode); x.a_y = coord(mode); x.a_z = coord(mode);
    x.b_x = coord(mode); x.b_y = coord(mode); x.b_z = coord(mode);
    x.c_x = coord(mode); x.c_y = coord(mode); x.c_z = coord(mode);
    x.d_x = coord(mode); x.d_y = coord(mode); x.d_z = coord(mode);
    // A few shapes force zero normals or mirrored and coplanar wings.
    case (shape)
      0: begin x.d_x = x.c_x; x.d_y = x.c_y; x.d_z = x.c_z; end
      1: begin x.b_x = x.a_x; x.b_y = x.a_y; x.b_z = x.a_z; end
      2: begin x.c_x = x.b_x; x.c_y = x.b_y; x.c_z = x.b_z; end
      3: begin x.d_x = x.a_x; x.d_y = x.a_y; x.d_z = x.a_z; end
      4: begin
        x.d_x = 2 * x.a_x - x.c_x; x.d_y = 2 * x.a_y - x.c_y;
        x.d_z = 2 * x.a_z - x.c_z;
      end
      default: ;
    endcase
    return x;
  endfunction

  function automatic dra_in_t quad(int ax, int ay, int az, int bx, int by, int bz,
                                   int cx, int cy, int cz, int dx, int dy, int dz);
    dra_in_t x;
    x = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
    return x;
  endfunction

  initial begin
    localparam int ONE = 1 << 16;
    localparam int MX = 32'sh7FFF_FFFF;
    localparam int MN = 32'sh8000_0000;
    dra_in_t x;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: zero normals, right angle, flat and folded wings, extremes.
    idle_pct = 7;
    send_word('0);
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0));
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, -ONE, 0));
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 5, 0, 0));
    send_word(quad(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 0, ONE, 0));
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, ONE, 0, ONE, -ONE));
    send_word(quad(MN, MN, MN, MX, MX, MX, MN, MX, MN, MX, MN, MX));
    send_word(quad(MX, MN, MX, MN, MX, MN, MX, MX, MN, MN, MN, MX));
    send_word(quad(MN, 0, 0, MX, 0, 0, MN, MX, 0, MN, MN, MX));
    send_word(quad(MX, MX, MX, MN, MN, MN, MX, MN, MX, MN, MX, MN));
    send_word(quad(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_word(quad(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -1, 0));
    send_word(quad(0, 0, 0, MX, 0, 0, 0, 1, 0, 0, 1, 1));
    send_word(quad(-1, -1, -1, -1, -1, -1, 5, 6, 7, 8, 9, 10));
    send_word(quad(0, 0, 0, ONE, ONE, ONE, 3, -7, 2, 3, -7, 2));
    send_word(quad(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 1));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 45 : 0;
      for (int i = 0; i < 230; i++) begin
        x = random_quad();
        send_word(x);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words in, %0d results out, %0d degenerate",
             sb.words_in, sb.words_out, sb.degenerate_seen);
    $display("sender gaps of 7, 45 and 0 percent, reset held 11 cycles");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dra_pkg.sv
rtl/core/dra_isqrt.sv
rtl/core/dra_acos.sv
rtl/core/dihedral_rest_angle.sv
rtl/core/dra_checker.sv
dv/testbench.sv
